>>> hw/rtl/dsm_pkg.sv
// Shared types, register indexes and constants for the disturbance severity monitor.
`timescale 1ns / 1ps
`default_nettype none

package dsm_pkg;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;
    localparam logic [CFG_INDEX_W-1:0] REG_SMOOTHING_ALPHA   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RECOVERABLE_LIMIT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COMMAND_LIMIT     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ABORT_SAMPLES     = 2'd3;

    // Register reset values.
    localparam logic [16:0] ALPHA_RESET       = 17'd16384;
    localparam logic [14:0] REC_LIMIT_RESET   = 15'd4096;
    localparam logic [14:0] CMD_LIMIT_RESET   = 15'd2048;
    localparam logic [7:0]  ABORT_SAMP_RESET  = 8'd10;

    // Arithmetic constants.
    localparam logic [16:0] ALPHA_ONE      = 17'd65536;
    localparam logic [9:0]  PERMILLE_FULL  = 10'd1000;
    localparam logic [15:0] NEAR_GROUND_MM = 16'd80;
    localparam logic [7:0]  RUN_MAX        = 8'd255;

    // Iteration counts of the square root and the permille division.
    localparam int SQRT_STEPS = 16;
    localparam int DIV_STEPS  = 10;
    localparam int CNT_W      = 4;

    // Severity class codes.
    localparam logic [1:0] CLASS_NONE            = 2'd0;
    localparam logic [1:0] CLASS_RECOVERABLE     = 2'd1;
    localparam logic [1:0] CLASS_NONRECOVERABLE  = 2'd2;

    // Input transaction payload.
    typedef struct packed {
        logic               flow_live;
        logic signed [15:0] vx_measured;
        logic signed [15:0] vy_measured;
        logic [15:0]        down_range_mm;
    } dsm_in_t;

    // Result transaction payload.
    typedef struct packed {
        logic               result_valid;
        logic signed [15:0] vx_command;
        logic signed [15:0] vy_command;
        logic [9:0]         severity_permille;
        logic               is_recoverable;
        logic [1:0]         severity_class;
        logic               near_ground;
        logic               abort_request;
    } dsm_out_t;

    // Operand selection of the shared multiplier.
    typedef enum logic [2:0] {
        MUL_FILT_X,
        MUL_FILT_Y,
        MUL_SQ_X,
        MUL_SQ_Y,
        MUL_LIM_SQ,
        MUL_PERMILLE
    } dsm_mul_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic         load;
        dsm_mul_sel_t mul_sel;
        logic         upd_x;
        logic         upd_y;
        logic         acc_clear;
        logic         acc_add;
        logic         cmp_lim;
        logic         sqrt_step;
        logic         div_init;
        logic         div_step;
        logic         finish;
    } dsm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic live;
    } dsm_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/dsm_ctrl.sv
// Controller state machine that sequences the monitor datapath.
`timescale 1ns / 1ps
`default_nettype none

module dsm_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               sample_valid,
    output logic                    sample_ready,
    output logic                    report_valid,
    input  wire logic               report_ready,
    input  wire dsm_pkg::dsm_stat_t stat,
    output dsm_pkg::dsm_cmd_t       cmd
);
    import dsm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILT_X,
        ST_FILT_Y,
        ST_SQ_X,
        ST_SQ_Y,
        ST_LIM,
        ST_CMP,
        ST_SQRT,
        ST_PERM,
        ST_DIV_INIT,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             report_valid_reg, report_valid_next;

    assign sample_ready = (state_reg == ST_IDLE);
    assign report_valid = report_valid_reg;

    // Next state and datapath commands.
    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        report_valid_next = report_valid_reg && !report_ready;
        cmd               = '0;
        cmd.mul_sel       = MUL_FILT_X;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_FILT_X;
                end
            end
            ST_FILT_X:
            begin
                cmd.mul_sel = MUL_FILT_X;
                state_next  = stat.live ? ST_FILT_Y : ST_DONE;
            end
            ST_FILT_Y:
            begin
                cmd.mul_sel = MUL_FILT_Y;
                cmd.upd_x   = 1'b1;
                state_next  = ST_SQ_X;
            end
            ST_SQ_X:
            begin
                cmd.mul_sel = MUL_SQ_X;
                cmd.upd_y   = 1'b1;
                state_next  = ST_SQ_Y;
            end
            ST_SQ_Y:
            begin
                cmd.mul_sel   = MUL_SQ_Y;
                cmd.acc_clear = 1'b1;
                state_next    = ST_LIM;
            end
            ST_LIM:
            begin
                cmd.mul_sel = MUL_LIM_SQ;
                cmd.acc_add = 1'b1;
                state_next  = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.cmp_lim = 1'b1;
                cnt_next    = '0;
                state_next  = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                begin
                    state_next = ST_PERM;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_PERM:
            begin
                cmd.mul_sel = MUL_PERMILLE;
                state_next  = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                // Wait until the output register is free.
                if (!report_valid_reg || report_ready)
                begin
                    cmd.finish        = 1'b1;
                    report_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, counter and result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            report_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            report_valid_reg <= report_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/dsm_dpath.sv
// Datapath of the monitor: filter, shared multiplier, square root and divider.
`timescale 1ns / 1ps
`default_nettype none

module dsm_dpath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [dsm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [dsm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire dsm_pkg::dsm_in_t                   sample,
    input  wire dsm_pkg::dsm_cmd_t                  cmd,
    output dsm_pkg::dsm_stat_t                      stat,
    output dsm_pkg::dsm_out_t                       report
);
    import dsm_pkg::*;

    // Negate a smoothed velocity and clamp it to the command limit.
    function automatic logic [15:0] clamp_cmd(input logic [15:0] s, input logic [14:0] cl);
        logic signed [16:0] neg;
        logic signed [16:0] lim;
        logic signed [16:0] res;
        neg = -$signed({s[15], s});
        lim = $signed({2'b00, cl});
        if (neg > lim)
        begin
            res = lim;
        end
        else if (neg < -lim)
        begin
            res = -lim;
        end
        else
        begin
            res = neg;
        end
        return res[15:0];
    endfunction

    // Configuration registers.
    logic [16:0] alpha_reg;
    logic [14:0] rec_limit_reg;
    logic [14:0] cmd_limit_reg;
    logic [7:0]  abort_samp_reg;

    // Filter state and run counter.
    logic signed [15:0] sx_reg, sy_reg;
    logic [7:0]         run_reg, run_next;

    // Working registers.
    dsm_in_t            inp_reg;
    logic signed [35:0] prod_reg;
    logic [31:0]        sq_reg;
    logic               rec_reg;
    logic               zero_reg;
    logic [17:0]        rem_reg;
    logic [15:0]        root_reg;
    logic [24:0]        num_reg;
    logic [23:0]        dvs_reg;
    logic [9:0]         quo_reg;
    dsm_out_t           report_reg;

    // Effective register values.
    logic [16:0] alpha_eff;
    logic [14:0] lim_eff;
    assign alpha_eff = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign lim_eff   = (rec_limit_reg == '0) ? 15'd1 : rec_limit_reg;

    assign stat.live = inp_reg.flow_live;
    assign report    = report_reg;

    // Shared multiplier operand selection.
    logic signed [16:0] diff_x, diff_y;
    logic signed [17:0] mul_a, mul_b;
    logic [14:0]        bounded;

    assign diff_x  = $signed({inp_reg.vx_measured[15], inp_reg.vx_measured})
                   - $signed({sx_reg[15], sx_reg});
    assign diff_y  = $signed({inp_reg.vy_measured[15], inp_reg.vy_measured})
                   - $signed({sy_reg[15], sy_reg});
    assign bounded = (root_reg > {1'b0, lim_eff}) ? lim_eff : root_reg[14:0];

    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_FILT_X:
            begin
                mul_a = $signed({1'b0, alpha_eff});
                mul_b = $signed({diff_x[16], diff_x});
            end
            MUL_FILT_Y:
            begin
                mul_a = $signed({1'b0, alpha_eff});
                mul_b = $signed({diff_y[16], diff_y});
            end
            MUL_SQ_X:
            begin
                mul_a = $signed({{2{sx_reg[15]}}, sx_reg});
                mul_b = $signed({{2{sx_reg[15]}}, sx_reg});
            end
            MUL_SQ_Y:
            begin
                mul_a = $signed({{2{sy_reg[15]}}, sy_reg});
                mul_b = $signed({{2{sy_reg[15]}}, sy_reg});
            end
            MUL_LIM_SQ:
            begin
                mul_a = $signed({3'b000, lim_eff});
                mul_b = $signed({3'b000, lim_eff});
            end
            MUL_PERMILLE:
            begin
                mul_a = $signed({3'b000, bounded});
                mul_b = $signed({8'd0, PERMILLE_FULL});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Filter update: s + floor((alpha * (m - s) + 32768) / 65536), saturated.
    logic signed [35:0] prod_rnd;
    logic signed [19:0] filt_step;
    logic signed [15:0] filt_base;
    logic signed [20:0] filt_sum;
    logic signed [15:0] filt_new;

    assign prod_rnd  = prod_reg + 36'sd32768;
    assign filt_step = prod_rnd[35:16];
    assign filt_base = cmd.upd_y ? sy_reg : sx_reg;
    assign filt_sum  = $signed({{5{filt_base[15]}}, filt_base})
                     + $signed({filt_step[19], filt_step});

    always_comb
    begin
        if (filt_sum > 21'sd32767)
        begin
            filt_new = 16'sh7FFF;
        end
        else if (filt_sum < -21'sd32768)
        begin
            filt_new = -16'sd32768;
        end
        else
        begin
            filt_new = filt_sum[15:0];
        end
    end

    // One square root digit: bring down two radicand bits and try to subtract.
    logic [18:0] rem_sh;
    logic [18:0] trial;
    logic        sqrt_take;
    assign rem_sh    = {rem_reg[16:0], sq_reg[31:30]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign sqrt_take = (rem_sh >= trial);

    // One restoring division step.
    logic div_take;
    assign div_take = (num_reg >= {1'b0, dvs_reg});

    // Run counter and result fields.
    logic [9:0] permille;
    assign permille = (quo_reg > PERMILLE_FULL) ? PERMILLE_FULL : quo_reg;

    always_comb
    begin
        if (rec_reg)
        begin
            run_next = '0;
        end
        else if (run_reg == RUN_MAX)
        begin
            run_next = RUN_MAX;
        end
        else
        begin
            run_next = run_reg + 1'b1;
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg      <= ALPHA_RESET;
            rec_limit_reg  <= REC_LIMIT_RESET;
            cmd_limit_reg  <= CMD_LIMIT_RESET;
            abort_samp_reg <= ABORT_SAMP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SMOOTHING_ALPHA:   alpha_reg      <= cfg_data;
                REG_RECOVERABLE_LIMIT: rec_limit_reg  <= cfg_data[14:0];
                REG_COMMAND_LIMIT:     cmd_limit_reg  <= cfg_data[14:0];
                REG_ABORT_SAMPLES:     abort_samp_reg <= cfg_data[7:0];
                default:               alpha_reg      <= alpha_reg;
            endcase
        end
    end

    // Filter state and run counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg  <= '0;
            sy_reg  <= '0;
            run_reg <= '0;
        end
        else
        begin
            if (cmd.upd_x)
            begin
                sx_reg <= filt_new;
            end
            if (cmd.upd_y)
            begin
                sy_reg <= filt_new;
            end
            if (cmd.finish)
            begin
                if (inp_reg.flow_live)
                begin
                    run_reg <= run_next;
                end
                else
                begin
                    sx_reg  <= '0;
                    sy_reg  <= '0;
                    run_reg <= '0;
                end
            end
        end
    end

    // Working registers and the result register.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd.load)
        begin
            inp_reg <= sample;
        end
        if (cmd.acc_clear)
        begin
            sq_reg <= prod_reg[31:0];
        end
        if (cmd.acc_add)
        begin
            sq_reg <= sq_reg + prod_reg[31:0];
        end
        if (cmd.cmp_lim)
        begin
            rec_reg  <= (sq_reg <= prod_reg[31:0]);
            zero_reg <= (sq_reg == '0);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (cmd.sqrt_step)
        begin
            sq_reg <= {sq_reg[29:0], 2'b00};
            if (sqrt_take)
            begin
                rem_reg  <= 18'(rem_sh - trial);
                root_reg <= {root_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[17:0];
                root_reg <= {root_reg[14:0], 1'b0};
            end
        end
        if (cmd.div_init)
        begin
            num_reg <= prod_reg[24:0] + {11'd0, lim_eff[14:1]};
            dvs_reg <= {lim_eff, 9'd0};
            quo_reg <= '0;
        end
        if (cmd.div_step)
        begin
            dvs_reg <= {1'b0, dvs_reg[23:1]};
            if (div_take)
            begin
                num_reg <= num_reg - {1'b0, dvs_reg};
                quo_reg <= {quo_reg[8:0], 1'b1};
            end
            else
            begin
                quo_reg <= {quo_reg[8:0], 1'b0};
            end
        end
        if (cmd.finish)
        begin
            if (inp_reg.flow_live)
            begin
                report_reg.result_valid      <= 1'b1;
                report_reg.vx_command        <= clamp_cmd(sx_reg, cmd_limit_reg);
                report_reg.vy_command        <= clamp_cmd(sy_reg, cmd_limit_reg);
                report_reg.severity_permille <= permille;
                report_reg.is_recoverable    <= rec_reg;
                report_reg.severity_class    <= zero_reg ? CLASS_NONE :
                                                (rec_reg ? CLASS_RECOVERABLE
                                                         : CLASS_NONRECOVERABLE);
                report_reg.near_ground       <= (inp_reg.down_range_mm != '0) &&
                                                (inp_reg.down_range_mm < NEAR_GROUND_MM);
                report_reg.abort_request     <= (run_next >= abort_samp_reg);
            end
            else
            begin
                report_reg <= '0;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/disturbance_severity_monitor_top.sv
// Top level of the disturbance severity monitor.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                                Width        Direction
// sample    sample_valid, sample_ready, sample     dsm_in_t     in
// report    report_valid, report_ready, report     dsm_out_t    out
// config    cfg_we, cfg_index, cfg_data            2 / 17 bits  in
//
// A live sample raises report_valid after the filter, square and limit products,
// a compare, 16 square root iterations, the permille product, a divider load, 10
// division iterations and the result write. The next sample can be taken in the
// cycle after that write; one without live flow goes from the x filter step to it.
// Reset is asynchronous and active low; it loads the register defaults and clears
// the filter state. An untaken result holds the controller before its next write.

module disturbance_severity_monitor_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            sample_valid,
    output logic                                 sample_ready,
    input  wire dsm_pkg::dsm_in_t                sample,
    output logic                                 report_valid,
    input  wire logic                            report_ready,
    output dsm_pkg::dsm_out_t                    report,
    input  wire logic                            cfg_we,
    input  wire logic [dsm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [dsm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dsm_pkg::*;

    dsm_cmd_t  cmd;
    dsm_stat_t stat;

    // Sequencing.
    dsm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .report_valid (report_valid),
        .report_ready (report_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    // Arithmetic and state.
    dsm_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .cmd       (cmd),
        .stat      (stat),
        .report    (report)
    );

endmodule

`default_nettype wire
